### rtl/core/spm_pkg.sv
package spm_pkg;

	// permutation length and store geometry
	localparam int MAX_LEN = 256;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CNT_W   = 9;
	localparam int ELEM_W  = 10;
	localparam int INV_W   = 15;
	localparam int MAG_W   = 9;

	localparam logic [CNT_W-1:0] SAT_CNT       = '1;
	localparam logic [INV_W-1:0] SAT_INV       = '1;
	localparam logic [MAG_W-1:0] SAT_MAG       = '1;
	localparam logic [CNT_W-1:0] LIMIT_RST     = CNT_W'(257);
	localparam logic [CNT_W-1:0] MAX_LEN_CNT   = CNT_W'(MAX_LEN);

	// saturating increment of a small counter
	function automatic logic [CNT_W-1:0] bump_cnt(input logic [CNT_W-1:0] c, input logic en);
		logic [CNT_W-1:0] r;
		r = c;
		if (en && (c != SAT_CNT)) begin
			r = c + CNT_W'(1);
		end
		return r;
	endfunction

endpackage

### rtl/core/spm_ram.sv
module spm_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/signed_permutation_metrics_top.sv
// Signed permutation metrics. Elements of a signed permutation arrive one word at a time on
// the input channel, the first at position 1 (position 0 holds an implicit 0); the word
// marked last, or the one that fills position 256, closes the permutation and one result
// word follows on the output channel: inversion count over magnitudes, negative count,
// even-displacement negatives, odd-displacement positives, reversal and transposition
// breakpoints (an implicit element n+1 closes the sequence), the within-lambda flag and the
// length. Magnitudes live in a 256-entry RAM; each element is compared against every stored
// magnitude, one RAM read per cycle, in a scan step and then an update step (the scan of the
// first element is empty), and the closing element then passes through an emit step that
// loads the result register, waiting there while the previous result word is still stalled
// in it. A new element is taken while a result still waits on the output. lambda_limit may
// be written at any time the block is idle; it resets to 257.
module signed_permutation_metrics_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// element channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [spm_pkg::ELEM_W-1:0] element,
	input  logic                            last,
	// lambda limit register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [spm_pkg::CNT_W-1:0]       lambda_limit,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [spm_pkg::INV_W-1:0]       inversions,
	output logic [spm_pkg::CNT_W-1:0]       negatives,
	output logic [spm_pkg::CNT_W-1:0]       even_negative,
	output logic [spm_pkg::CNT_W-1:0]       odd_positive,
	output logic [spm_pkg::CNT_W-1:0]       reversal_breakpoints,
	output logic [spm_pkg::CNT_W-1:0]       transposition_breakpoints,
	output logic                            within_lambda,
	output logic [spm_pkg::CNT_W-1:0]       length
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic                              rd_valid_s1;
	logic [spm_pkg::CNT_W-1:0]         rd_q;
	logic signed [spm_pkg::ELEM_W-1:0] elem_q;
	logic                              last_q;
	logic [spm_pkg::CNT_W-1:0]         loaded_q;
	logic signed [spm_pkg::ELEM_W-1:0] prev_q;
	logic [spm_pkg::INV_W-1:0]         inv_q;
	logic [spm_pkg::CNT_W-1:0]         neg_q;
	logic [spm_pkg::CNT_W-1:0]         even_neg_q;
	logic [spm_pkg::CNT_W-1:0]         odd_pos_q;
	logic [spm_pkg::CNT_W-1:0]         rev_q;
	logic [spm_pkg::CNT_W-1:0]         trans_q;
	logic                              lambda_ok_q;
	logic [spm_pkg::CNT_W-1:0]         lambda_q;

	logic                              out_valid_q;
	logic [spm_pkg::INV_W-1:0]         inversions_q;
	logic [spm_pkg::CNT_W-1:0]         negatives_q;
	logic [spm_pkg::CNT_W-1:0]         even_negative_q;
	logic [spm_pkg::CNT_W-1:0]         odd_positive_q;
	logic [spm_pkg::CNT_W-1:0]         rev_bp_q;
	logic [spm_pkg::CNT_W-1:0]         trans_bp_q;
	logic                              within_lambda_q;
	logic [spm_pkg::CNT_W-1:0]         length_q;

	logic                              in_take;
	logic                              out_free;
	logic                              ram_re;
	logic                              ram_we;
	logic [spm_pkg::MAG_W-1:0]         ram_rdata;
	logic [spm_pkg::ELEM_W-1:0]        mag;
	logic [spm_pkg::MAG_W-1:0]         stored;
	logic [spm_pkg::CNT_W-1:0]         pos;
	logic signed [11:0]                disp_sig;
	logic [11:0]                       disp_abs;
	logic                              disp_odd;
	logic                              elem_neg;
	logic                              elem_pos;
	logic signed [10:0]                diff;
	logic                              rev_hit;
	logic                              trans_hit;
	logic                              final_elem;
	logic [9:0]                        next_elem;
	logic signed [11:0]                end_diff;
	logic                              end_rev_hit;
	logic                              end_trans_hit;
	logic                              scan_done;

	// handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// magnitude of the held element, clipped for the store
	always_comb begin
		mag    = elem_q[spm_pkg::ELEM_W-1] ? (~elem_q + 10'sd1) : elem_q;
		stored = mag[spm_pkg::ELEM_W-1] ? spm_pkg::SAT_MAG : mag[spm_pkg::MAG_W-1:0];
	end

	// displacement, sign classes and breakpoint against the previous element
	always_comb begin
		pos        = loaded_q + spm_pkg::CNT_W'(1);
		disp_sig   = $signed({2'b00, mag}) - $signed({3'b000, pos});
		disp_abs   = disp_sig[11] ? 12'(-disp_sig) : 12'(disp_sig);
		disp_odd   = mag[0] ^ pos[0];
		elem_neg   = elem_q[spm_pkg::ELEM_W-1];
		elem_pos   = !elem_neg && (elem_q != '0);
		diff       = 11'(elem_q) - 11'(prev_q);
		rev_hit    = (diff != 11'sd1) && (diff != -11'sd1);
		trans_hit  = (diff != 11'sd1);
		final_elem = last_q || (pos == spm_pkg::MAX_LEN_CNT);
	end

	// closing breakpoint against the implicit element n+1
	always_comb begin
		next_elem     = {1'b0, loaded_q} + 10'd1;
		end_diff      = $signed({2'b00, next_elem}) - 12'(prev_q);
		end_rev_hit   = (end_diff != 12'sd1) && (end_diff != -12'sd1);
		end_trans_hit = (end_diff != 12'sd1);
	end

	// magnitude store access
	assign ram_re    = (state_q == ST_SCAN) && (rd_q < loaded_q);
	assign ram_we    = (state_q == ST_UPDATE) && (loaded_q < spm_pkg::MAX_LEN_CNT);
	assign scan_done = (rd_q == loaded_q) && !rd_valid_s1;

	spm_ram #(
		.WIDTH(spm_pkg::MAG_W),
		.DEPTH(spm_pkg::MAX_LEN)
	) u_mag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(loaded_q[spm_pkg::ADDR_W-1:0]),
		.wdata(stored),
		.re   (ram_re),
		.raddr(rd_q[spm_pkg::ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// sequencer, running totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rd_valid_s1     <= 1'b0;
			rd_q            <= '0;
			loaded_q        <= '0;
			prev_q          <= '0;
			inv_q           <= '0;
			neg_q           <= '0;
			even_neg_q      <= '0;
			odd_pos_q       <= '0;
			rev_q           <= '0;
			trans_q         <= '0;
			lambda_ok_q     <= 1'b1;
			lambda_q        <= spm_pkg::LIMIT_RST;
			out_valid_q     <= 1'b0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready) begin
				lambda_q <= lambda_limit;
			end

			// result word taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			rd_valid_s1 <= ram_re;

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						rd_q    <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						rd_q <= rd_q + spm_pkg::CNT_W'(1);
					end
					// count stored magnitudes above this one
					if (rd_valid_s1 && (ram_rdata > stored) && (inv_q != spm_pkg::SAT_INV)) begin
						inv_q <= inv_q + spm_pkg::INV_W'(1);
					end
					if (scan_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					neg_q      <= spm_pkg::bump_cnt(neg_q, elem_neg);
					even_neg_q <= spm_pkg::bump_cnt(even_neg_q, elem_neg && !disp_odd);
					odd_pos_q  <= spm_pkg::bump_cnt(odd_pos_q, elem_pos && disp_odd);
					rev_q      <= spm_pkg::bump_cnt(rev_q, rev_hit);
					trans_q    <= spm_pkg::bump_cnt(trans_q, trans_hit);
					if (disp_abs >= {3'b000, lambda_q}) begin
						lambda_ok_q <= 1'b0;
					end
					prev_q   <= elem_q;
					loaded_q <= pos;
					state_q  <= final_elem ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						inversions_q    <= inv_q;
						negatives_q     <= neg_q;
						even_negative_q <= even_neg_q;
						odd_positive_q  <= odd_pos_q;
						rev_bp_q        <= spm_pkg::bump_cnt(rev_q, end_rev_hit);
						trans_bp_q      <= spm_pkg::bump_cnt(trans_q, end_trans_hit);
						within_lambda_q <= lambda_ok_q;
						length_q        <= loaded_q;
						// back to the empty permutation
						loaded_q    <= '0;
						prev_q      <= '0;
						inv_q       <= '0;
						neg_q       <= '0;
						even_neg_q  <= '0;
						odd_pos_q   <= '0;
						rev_q       <= '0;
						trans_q     <= '0;
						lambda_ok_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// element and last mark held for the whole item
	always_ff @(posedge clk) begin
		if (in_take) begin
			elem_q <= element;
			last_q <= last;
		end
	end

	assign out_valid                 = out_valid_q;
	assign inversions                = inversions_q;
	assign negatives                 = negatives_q;
	assign even_negative             = even_negative_q;
	assign odd_positive              = odd_positive_q;
	assign reversal_breakpoints      = rev_bp_q;
	assign transposition_breakpoints = trans_bp_q;
	assign within_lambda             = within_lambda_q;
	assign length                    = length_q;

	// a result word only ever appears out of the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result word raised outside emit");

	// the scan never reads beyond the loaded elements
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_q <= loaded_q))
		else $error("scan address past loaded count");

	// the store is never written beyond its depth
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (loaded_q < spm_pkg::MAX_LEN_CNT))
		else $error("store write past depth");

	// a full store always closes the permutation
	a_full_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && pos == spm_pkg::MAX_LEN_CNT) |=> (state_q == ST_EMIT))
		else $error("full store did not close the permutation");

endmodule
